[rtl/i2cm_pkg.sv]
// Shared constants, opcodes and queue entry type for the I2C bit sequencer.
`default_nettype none

package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;
  // Longest phase run: two phases per bit plus ack slot and closing phases.
  localparam int PHASE_MAX     = 2 * BITS_PER_BYTE + 3;
  localparam int LEN_W         = $clog2(PHASE_MAX + 1);
  localparam int SB_W          = BITS_PER_BYTE + 1;

  localparam int START_LEN     = 4;
  localparam int STOP_LEN      = 3;
  localparam int BYTE_LEN      = PHASE_MAX;

  // Command queue between front and back
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // One decoded request: phase patterns (bit 0 first), run length, results.
  typedef struct packed {
    logic [PHASE_MAX-1:0]     scl_pat;
    logic [PHASE_MAX-1:0]     sda_pat;
    logic [LEN_W-1:0]         len;
    logic                     follow;   // first phase keeps the current SCL level
    logic [BITS_PER_BYTE-1:0] rx_byte;
    logic                     nack;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/i2cm_front.sv]
// Front end: accepts a request and expands it into phase patterns.
`default_nettype none

module i2cm_front (
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_op,
  input  wire logic [i2cm_pkg::BITS_PER_BYTE-1:0] in_tx_byte,
  input  wire logic [i2cm_pkg::SB_W-1:0]         in_slave_bits,
  input  wire logic                              q_ready,
  output logic                                   q_push,
  output i2cm_pkg::cmd_t                         q_entry
);
  import i2cm_pkg::*;

  // Handshake passes straight to the queue
  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  // Decode opcode into per-phase SCL/SDA levels
  always_comb begin
    q_entry = '0;
    case (in_op)
      OP_START: begin
        q_entry.len     = LEN_W'(START_LEN);
        q_entry.follow  = 1'b1;
        q_entry.scl_pat[1] = 1'b1;
        q_entry.scl_pat[2] = 1'b1;
        q_entry.sda_pat[0] = 1'b1;
        q_entry.sda_pat[1] = 1'b1;
      end
      OP_STOP: begin
        q_entry.len     = LEN_W'(STOP_LEN);
        q_entry.follow  = 1'b1;
        q_entry.scl_pat[1] = 1'b1;
        q_entry.scl_pat[2] = 1'b1;
        q_entry.sda_pat[2] = 1'b1;
      end
      OP_WRITE: begin
        q_entry.len  = LEN_W'(BYTE_LEN);
        q_entry.nack = in_slave_bits[0];
        for (int i = 0; i < BITS_PER_BYTE; i++) begin
          q_entry.scl_pat[2*i+1] = 1'b1;
          q_entry.sda_pat[2*i]   = in_tx_byte[BITS_PER_BYTE-1-i];
          q_entry.sda_pat[2*i+1] = in_tx_byte[BITS_PER_BYTE-1-i];
        end
        // ack slot: release SDA, clock once, drop SCL
        q_entry.sda_pat[2*BITS_PER_BYTE]   = 1'b1;
        q_entry.scl_pat[2*BITS_PER_BYTE+1] = 1'b1;
        q_entry.sda_pat[2*BITS_PER_BYTE+1] = 1'b1;
        q_entry.sda_pat[2*BITS_PER_BYTE+2] = 1'b1;
      end
      OP_READ: begin
        q_entry.len     = LEN_W'(BYTE_LEN);
        q_entry.rx_byte = in_slave_bits[BITS_PER_BYTE:1];
        q_entry.sda_pat[0] = 1'b1;
        for (int i = 0; i < BITS_PER_BYTE; i++) begin
          q_entry.scl_pat[2*i+1] = 1'b1;
          q_entry.sda_pat[2*i+1] = 1'b1;
          q_entry.sda_pat[2*i+2] = (i != BITS_PER_BYTE - 1);
        end
        // master ack: SDA held low across one clock
        q_entry.scl_pat[2*BITS_PER_BYTE+1] = 1'b1;
        q_entry.sda_pat[2*BITS_PER_BYTE+2] = 1'b1;
      end
      default: q_entry = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/i2cm_queue.sv]
// Short request queue between the front end and the phase sequencer.
`default_nettype none

module i2cm_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire i2cm_pkg::cmd_t  push_entry,
  output logic                 push_ready,
  input  wire logic            pop,
  output logic                 head_valid,
  output i2cm_pkg::cmd_t       head_entry
);
  import i2cm_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[rtl/i2cm_back.sv]
// Back end: plays out one phase per cycle, unless out_ready stalls, into the registered result port.
`default_nettype none

module i2cm_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_valid,
  input  wire i2cm_pkg::cmd_t                     q_head,
  output logic                                    q_pop,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_scl,
  output logic                                    out_sda,
  output logic                                    out_last,
  output logic [i2cm_pkg::BITS_PER_BYTE-1:0]      out_rx_byte,
  output logic                                    out_nack
);
  import i2cm_pkg::*;

  logic                     active_r, active_nxt;
  logic [LEN_W-1:0]         cnt_r, cnt_nxt;
  logic [PHASE_MAX-1:0]     scl_sh_r, scl_sh_nxt;
  logic [PHASE_MAX-1:0]     sda_sh_r, sda_sh_nxt;
  logic [BITS_PER_BYTE-1:0] rx_r, rx_nxt;
  logic                     nack_r, nack_nxt;
  logic                     scl_level_r, scl_level_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_scl_r, out_scl_nxt;
  logic                     out_sda_r, out_sda_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [BITS_PER_BYTE-1:0] out_rx_r, out_rx_nxt;
  logic                     out_nack_r, out_nack_nxt;

  logic produce;
  logic emit;
  logic ph_scl, ph_sda, ph_last, ph_nack;
  logic [BITS_PER_BYTE-1:0] ph_rx;

  // Output register free or being drained this cycle
  assign produce = !out_valid_r || out_ready;
  assign emit    = produce && (active_r || q_valid);
  assign q_pop   = produce && !active_r && q_valid;

  // Current phase: from the running request, or the first phase of the head
  always_comb begin
    if (active_r) begin
      ph_scl  = scl_sh_r[0];
      ph_sda  = sda_sh_r[0];
      ph_last = (cnt_r == LEN_W'(1));
      ph_rx   = ph_last ? rx_r : '0;
      ph_nack = ph_last && nack_r;
    end else begin
      ph_scl  = q_head.follow ? scl_level_r : q_head.scl_pat[0];
      ph_sda  = q_head.sda_pat[0];
      ph_last = 1'b0;
      ph_rx   = '0;
      ph_nack = 1'b0;
    end
  end

  // Sequencer next state
  always_comb begin
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    scl_sh_nxt    = scl_sh_r;
    sda_sh_nxt    = sda_sh_r;
    rx_nxt        = rx_r;
    nack_nxt      = nack_r;
    scl_level_nxt = scl_level_r;
    out_valid_nxt = out_valid_r;
    out_scl_nxt   = out_scl_r;
    out_sda_nxt   = out_sda_r;
    out_last_nxt  = out_last_r;
    out_rx_nxt    = out_rx_r;
    out_nack_nxt  = out_nack_r;

    if (q_pop) begin
      active_nxt = 1'b1;
      cnt_nxt    = q_head.len - LEN_W'(1);
      scl_sh_nxt = q_head.scl_pat >> 1;
      sda_sh_nxt = q_head.sda_pat >> 1;
      rx_nxt     = q_head.rx_byte;
      nack_nxt   = q_head.nack;
    end else if (emit) begin
      cnt_nxt    = cnt_r - LEN_W'(1);
      scl_sh_nxt = scl_sh_r >> 1;
      sda_sh_nxt = sda_sh_r >> 1;
      if (cnt_r == LEN_W'(1)) begin
        active_nxt = 1'b0;
      end
    end

    if (emit) begin
      scl_level_nxt = ph_scl;
      out_valid_nxt = 1'b1;
      out_scl_nxt   = ph_scl;
      out_sda_nxt   = ph_sda;
      out_last_nxt  = ph_last;
      out_rx_nxt    = ph_rx;
      out_nack_nxt  = ph_nack;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cnt_r       <= '0;
      scl_level_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      scl_level_r <= scl_level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scl_sh_r   <= scl_sh_nxt;
    sda_sh_r   <= sda_sh_nxt;
    rx_r       <= rx_nxt;
    nack_r     <= nack_nxt;
    out_scl_r  <= out_scl_nxt;
    out_sda_r  <= out_sda_nxt;
    out_last_r <= out_last_nxt;
    out_rx_r   <= out_rx_nxt;
    out_nack_r <= out_nack_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_scl     = out_scl_r;
  assign out_sda     = out_sda_r;
  assign out_last    = out_last_r;
  assign out_rx_byte = out_rx_r;
  assign out_nack    = out_nack_r;

`ifndef ASSERT_OFF
  // A running request always has phases left
  a_active_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cnt_r != '0))
    else $error("sequencer active with zero phases left");

  // Taking a request from the queue starts a run
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> active_r)
    else $error("request popped but sequencer not running");

  // Result fields only appear on a closing phase with SCL low
  a_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_rx_r != '0) || out_nack_r)) |-> (out_last_r && !out_scl_r))
    else $error("rx_byte or nack set outside the closing phase");
`endif

endmodule

`default_nettype wire

[rtl/i2c_master_bit_sequencer.sv]
// Top level of the byte-level I2C master phase sequencer.
`default_nettype none

// Each accepted request (start, stop, write byte, read byte with ack) becomes
// a run of SCL/SDA phases on the out_ port, one phase per cycle: start has
// 4 phases, stop 3, write and read 19 each. The back-end sequencer emits one
// phase per cycle and is the only rate limit; runs of queued requests follow
// each other with no gap, and out_ready stalls stretch a run by the stall
// length. A two-entry request queue lets new requests be taken while a run
// plays out. out_last marks the final phase of a run, which carries rx_byte
// for a read and nack for a write; both are zero elsewhere. SCL is tracked as
// released after reset, and a start or stop issued with SCL high keeps SCL
// high on its first phase so the SDA edge forms a bus condition.
module i2c_master_bit_sequencer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_op,
  input  wire logic [i2cm_pkg::BITS_PER_BYTE-1:0] in_tx_byte,
  input  wire logic [i2cm_pkg::SB_W-1:0]          in_slave_bits,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_scl,
  output logic                                    out_sda,
  output logic                                    out_last,
  output logic [i2cm_pkg::BITS_PER_BYTE-1:0]      out_rx_byte,
  output logic                                    out_nack
);
  import i2cm_pkg::*;

  logic q_push, q_ready, q_pop, q_valid;
  cmd_t q_entry, q_head;

  // Request decode
  i2cm_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_tx_byte    (in_tx_byte),
    .in_slave_bits (in_slave_bits),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  // Decoupling queue
  i2cm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  // Phase sequencer and result register
  i2cm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_scl     (out_scl),
    .out_sda     (out_sda),
    .out_last    (out_last),
    .out_rx_byte (out_rx_byte),
    .out_nack    (out_nack)
  );

endmodule

`default_nettype wire
